// ===== sv/bmorph_pkg.sv =====
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared constants and types for the 3x3 binary morphology filter.
// ----------------------------------------------------------------------------
package bmorph_pkg;

   // Default line length the line store is sized for
   localparam int MAX_WIDTH_DEF = 1024;

   // Field widths
   localparam int PIX_W  = 8;
   localparam int MODE_W = 2;
   localparam int MASK_W = 9;
   localparam int WREG_W = 11;
   localparam int HREG_W = 13;
   localparam int WIN_N  = 9;

   // Register file
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int REG_IW = CSR_AW - 2;

   localparam logic [REG_IW-1:0] REG_MODE   = 3'd0;
   localparam logic [REG_IW-1:0] REG_MASK   = 3'd1;
   localparam logic [REG_IW-1:0] REG_OBJECT = 3'd2;
   localparam logic [REG_IW-1:0] REG_BACKGR = 3'd3;
   localparam logic [REG_IW-1:0] REG_WIDTH  = 3'd4;
   localparam logic [REG_IW-1:0] REG_HEIGHT = 3'd5;

   // Operating modes
   localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOUNDARY = 2'd2;

   // Input item kinds
   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Reset values
   localparam logic [MODE_W-1:0] MODE_RST   = MODE_ERODE;
   localparam logic [MASK_W-1:0] FULL_MASK  = 9'h1FF;
   localparam logic [PIX_W-1:0]  OBJECT_RST = 8'd0;
   localparam logic [PIX_W-1:0]  BACKGR_RST = 8'd255;
   localparam int                WIDTH_RST  = 1024;
   localparam logic [HREG_W-1:0] HEIGHT_RST = 13'd1024;
   localparam logic [HREG_W-1:0] MAX_HEIGHT = 13'd4096;

   // Result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   // Control that travels with one window step down the pipe
   typedef struct packed {
      logic valid;     // window shifts
      logic emit;      // a result leaves for this step
      logic top_ok;    // row above the centre is inside the image
      logic bot_ok;    // row below the centre is inside the image
      logic left_ok;   // column left of the centre is inside
      logic right_ok;  // column right of the centre is inside
      logic last;      // last result of the frame
   } bm_ctl_type;

endpackage

// ===== sv/binary_morphology_3x3.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 erode / dilate / boundary filter on 8-bit raster pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock while the result
// queue has room. The result for a centre pixel leaves when the pixel one row
// and one column further on has arrived (image_width+1 pixels later); drain
// items, or pushes once the frame is complete, then flush the last results of
// a frame (image_width+1, or image_width for a single row), one per item. A
// result reaches rsp_ through the line-store read, the window shift and the
// neighbourhood compare. The two previous rows live in one RAM of MAX_WIDTH
// words of two pixels, read and written back once per pixel, so the rate is
// set by that single read-modify-write per column. A frame of a single row
// holds req_tready low after its last pixel while the window moves into
// place. The line store needs no clearing after reset. Registers are to be
// written by the user only between frames; the block does not enforce it.
// image_width and image_height take effect as soon as they are written.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bmorph_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_in
   input  logic                                req_tuser,   // [0] func
   // result output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bmorph_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] pixel_out
   output logic                                rsp_tlast,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bmorph_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [bmorph_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [bmorph_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                csr_pready
);

   import bmorph_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int RW    = HREG_W;
   localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
   localparam int LW    = 2 * PIX_W;

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0] mode_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [PIX_W-1:0]  obj_ff;
   logic [PIX_W-1:0]  bg_ff;
   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic [WW-1:0]     w_eff_ff;
   logic [HREG_W-1:0] h_eff_ff;

   logic [REG_IW-1:0] csr_idx;
   logic              csr_wr;

   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // width in use: zero acts as one, clamp to the line store size
   function automatic logic [WW-1:0] clamp_width(input logic [WREG_W-1:0] v);
      int unsigned vi;
      vi = 32'(v);
      if (vi == 0) begin
         vi = 1;
      end else if (vi > 32'(MAX_WIDTH)) begin
         vi = 32'(MAX_WIDTH);
      end
      return WW'(vi);
   endfunction

   // height in use: zero acts as one, clamp to the row limit
   function automatic logic [HREG_W-1:0] clamp_height(input logic [HREG_W-1:0] v);
      logic [HREG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = HREG_W'(1);
      end else if (v > MAX_HEIGHT) begin
         r = MAX_HEIGHT;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RST;
         mask_ff   <= FULL_MASK;
         obj_ff    <= OBJECT_RST;
         bg_ff     <= BACKGR_RST;
         width_ff  <= WREG_W'(WIDTH_RST);
         height_ff <= HEIGHT_RST;
         w_eff_ff  <= WW'(W_RST);
         h_eff_ff  <= HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MODE:   mode_ff <= csr_pwdata[MODE_W-1:0];
            REG_MASK:   mask_ff <= csr_pwdata[MASK_W-1:0];
            REG_OBJECT: obj_ff  <= csr_pwdata[PIX_W-1:0];
            REG_BACKGR: bg_ff   <= csr_pwdata[PIX_W-1:0];
            REG_WIDTH: begin
               width_ff <= csr_pwdata[WREG_W-1:0];
               w_eff_ff <= clamp_width(csr_pwdata[WREG_W-1:0]);
            end
            REG_HEIGHT: begin
               height_ff <= csr_pwdata[HREG_W-1:0];
               h_eff_ff  <= clamp_height(csr_pwdata[HREG_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_MODE:   csr_prdata = CSR_DW'(mode_ff);
         REG_MASK:   csr_prdata = CSR_DW'(mask_ff);
         REG_OBJECT: csr_prdata = CSR_DW'(obj_ff);
         REG_BACKGR: csr_prdata = CSR_DW'(bg_ff);
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage 0: position counters, step decision, line-store read
   // ---------------------------------------------------------------------
   logic [CW-1:0]        in_col_ff, in_col_in;
   logic [RW-1:0]        in_row_ff, in_row_in;
   logic [CW-1:0]        out_col_ff, out_col_in;
   logic [RW-1:0]        out_row_ff, out_row_in;
   logic [WW-1:0]        lag_ff, lag_in;

   bm_ctl_type           s1_ctl_ff, s2_ctl_ff, s0_ctl;
   logic [CW-1:0]        s1_addr_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   logic                 s1_fwd_ff;
   logic [LW-1:0]        s1_fwd_data_ff;

   logic [OUT_CNT_W-1:0] out_cnt_ff;
   logic [OUT_CNT_W-1:0] busy;
   logic                 out_pop;

   logic                 complete, aligned, pad, room;
   logic                 acc, is_push, step, emit, last;
   logic [PIX_W-1:0]     s0_pix;
   logic [WW-1:0]        in_col_inc, out_col_inc;
   logic                 fwd_in;

   logic                 ram_wr_en;
   logic [LW-1:0]        ram_wr_data;
   logic [LW-1:0]        ram_rd_data;

   assign complete = in_row_ff >= h_eff_ff;
   assign aligned  = lag_ff == (w_eff_ff + WW'(1));
   // single-row frames: move the window into place before draining
   assign pad      = complete & ~aligned;

   // every step in flight that emits holds a queue slot
   assign busy       = out_cnt_ff + OUT_CNT_W'(s1_ctl_ff.emit) + OUT_CNT_W'(s2_ctl_ff.emit);
   assign room       = busy < OUT_CNT_W'(OUT_DEPTH);
   assign req_tready = ~pad & room;

   assign acc     = req_tvalid & req_tready;
   assign is_push = req_tuser == FUNC_PUSH;
   assign step    = pad | (acc & (complete | is_push));
   assign emit    = step & aligned;
   assign last    = emit & (out_row_ff == h_eff_ff - RW'(1))
                         & ({1'b0, out_col_ff} == w_eff_ff - WW'(1));
   assign s0_pix  = (acc & is_push & ~complete) ? req_tdata : '0;

   assign in_col_inc  = {1'b0, in_col_ff} + WW'(1);
   assign out_col_inc = {1'b0, out_col_ff} + WW'(1);

   // neighbourhood bounds for the centre that leaves with this step
   always_comb begin
      s0_ctl.valid    = step;
      s0_ctl.emit     = emit;
      s0_ctl.top_ok   = out_row_ff != '0;
      s0_ctl.bot_ok   = out_row_ff < (h_eff_ff - RW'(1));
      s0_ctl.left_ok  = out_col_ff != '0;
      s0_ctl.right_ok = {1'b0, out_col_ff} < (w_eff_ff - WW'(1));
      s0_ctl.last     = last;
   end

   // counter update
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      if (step) begin
         if (in_col_inc >= w_eff_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_inc[CW-1:0];
         end
         if (!emit) begin
            lag_in = lag_ff + WW'(1);
         end
      end
      if (emit) begin
         if (out_col_inc >= w_eff_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RW'(1);
         end else begin
            out_col_in = out_col_inc[CW-1:0];
         end
      end
      // frame done: start over
      if (last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
      end
   end

   // write-back of the previous step to the same column is still in flight
   assign fwd_in = step & s1_ctl_ff.valid & (s1_addr_ff == in_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s1_fwd_ff <= 1'b0;
      end else begin
         s1_ctl_ff <= s0_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s1_fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff     <= in_col_ff;
      s1_pix_ff      <= s0_pix;
      s1_fwd_data_ff <= ram_wr_data;
   end

   // two previous rows per column: [15:8] two rows up, [7:0] one row up
   bmorph_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (step),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage 1: write back the column and shift the window
   // ---------------------------------------------------------------------
   logic [LW-1:0]    line_word;
   logic [PIX_W-1:0] win_ff [WIN_N];

   assign line_word   = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign ram_wr_en   = s1_ctl_ff.valid;
   assign ram_wr_data = {line_word[PIX_W-1:0], s1_pix_ff};

   // window entry 3*row+col, column 2 newest
   always_ff @(posedge clock) begin
      if (s1_ctl_ff.valid) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[3*r]   <= win_ff[3*r+1];
            win_ff[3*r+1] <= win_ff[3*r+2];
         end
         win_ff[2] <= line_word[LW-1:PIX_W];
         win_ff[5] <= line_word[PIX_W-1:0];
         win_ff[8] <= s1_pix_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: neighbourhood compare
   // ---------------------------------------------------------------------
   logic [2:0]        row_ok, col_ok;
   logic [WIN_N-1:0]  obj_hit;
   logic [MASK_W-1:0] use_mask;
   logic              all_fit, any_hit;
   logic [PIX_W-1:0]  eroded, result;
   logic              out_push;

   assign row_ok = {s2_ctl_ff.bot_ok, 1'b1, s2_ctl_ff.top_ok};
   assign col_ok = {s2_ctl_ff.right_ok, 1'b1, s2_ctl_ff.left_ok};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            obj_hit[3*r+c] = row_ok[r] & col_ok[c] & (win_ff[3*r+c] == obj_ff);
         end
      end
   end

   assign use_mask = (mode_ff == MODE_ERODE || mode_ff == MODE_DILATE) ? mask_ff : FULL_MASK;
   assign all_fit  = &(obj_hit | ~use_mask);
   assign any_hit  = |(obj_hit & use_mask);
   assign eroded   = all_fit ? obj_ff : bg_ff;

   always_comb begin
      case (mode_ff)
         MODE_ERODE:  result = eroded;
         MODE_DILATE: result = any_hit ? obj_ff : bg_ff;
         // boundary: eroded minus centre, floored at zero
         default:     result = (eroded > win_ff[4]) ? eroded - win_ff[4] : '0;
      endcase
   end

   assign out_push = s2_ctl_ff.valid & s2_ctl_ff.emit;

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   logic [PIX_W-1:0]     q_pix_ff  [OUT_DEPTH];
   logic                 q_last_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] q_wp_ff, q_rp_ff;

   assign rsp_tvalid = out_cnt_ff != '0;
   assign rsp_tdata  = q_pix_ff[q_rp_ff];
   assign rsp_tlast  = q_last_ff[q_rp_ff];
   assign out_pop    = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (out_push) begin
         q_pix_ff[q_wp_ff]  <= result;
         q_last_ff[q_wp_ff] <= s2_ctl_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff    <= '0;
         q_rp_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (out_push) begin
            q_wp_ff <= q_wp_ff + OUT_PTR_W'(1);
         end
         if (out_pop) begin
            q_rp_ff <= q_rp_ff + OUT_PTR_W'(1);
         end
         out_cnt_ff <= out_cnt_ff + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // slot accounting keeps the queue from overflowing
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_pop) |-> (out_cnt_ff < OUT_CNT_W'(OUT_DEPTH)))
      else $error("result queue overflow");

   // the last result of a frame rewinds every position counter
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      last |=> (in_row_ff == '0 && out_row_ff == '0 && lag_ff == '0))
      else $error("counters not cleared at frame end");

   // forwarded line data only rides on back-to-back steps
   a_fwd_b2b: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> (s1_ctl_ff.valid && $past(s1_ctl_ff.valid)))
      else $error("line forward without a preceding step");

endmodule

// ===== sv/bmorph_ram.sv =====
// ----------------------------------------------------------------------------
// bmorph_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmorph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/binary_morphology_3x3_tb.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3_tb
// Self-checking bench for the streaming 3x3 erode / dilate / boundary filter.
// ----------------------------------------------------------------------------
// Pixel frames of many sizes and register settings are streamed into the
// block. The sender runs in bursts with random gaps, and the receiver stalls
// on a pattern of its own. A scoreboard keeps its own copy of the line store,
// the frame counters and the registers, and works out the result pixel and
// the frame-end flag for each transfer that makes one. Each result the block hands
// over is compared field by field with the oldest pending prediction.
// Registers are written over the APB-style port only between whole frames.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmorph_pkg::*;

   localparam int HIST_DEPTH  = 2 * MAX_WIDTH_DEF + 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PUSHES = 900;
   localparam int SETTLE_CYCLES = 8;
   // mode code left over in the 2-bit field; the block treats it as boundary
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } morph_pixel_t;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the filter output and checks what comes out
   // -------------------------------------------------------------------------
   class morph_scoreboard;
      bit [MODE_W-1:0] mode;
      bit [MASK_W-1:0] se_mask;
      bit [PIX_W-1:0]  obj_val;
      bit [PIX_W-1:0]  bg_val;
      bit [WREG_W-1:0] width_reg;
      bit [HREG_W-1:0] height_reg;
      bit [PIX_W-1:0]  history [HIST_DEPTH];
      int              in_col, in_row, out_col, out_row;
      morph_pixel_t    pending_q [$];
      int              errors;

      function new();
         mode       = MODE_RST;
         se_mask    = FULL_MASK;
         obj_val    = OBJECT_RST;
         bg_val     = BACKGR_RST;
         width_reg  = WIDTH_RST;
         height_reg = HEIGHT_RST;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [REG_IW-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_MODE:   mode       = value[MODE_W-1:0];
            REG_MASK:   se_mask    = value[MASK_W-1:0];
            REG_OBJECT: obj_val    = value[PIX_W-1:0];
            REG_BACKGR: bg_val     = value[PIX_W-1:0];
            REG_WIDTH:  width_reg  = value[WREG_W-1:0];
            REG_HEIGHT: height_reg = value[HREG_W-1:0];
            default: ;
         endcase
      endfunction

      // out-of-range sizes clamp to the nearest legal one
      function int active_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
         return int'(width_reg);
      endfunction

      function int active_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT) return int'(MAX_HEIGHT);
         return int'(height_reg);
      endfunction

      function void restart_frame();
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      endfunction

      // filter value for the centre at out_row / out_col
      function bit [PIX_W-1:0] filter_pixel(int w, int h);
         bit [MASK_W-1:0] use_mask;
         bit              all_fit, any_hit, hit;
         bit [PIX_W-1:0]  centre, res;
         int              r, c, k;
         all_fit  = 1'b1;
         any_hit  = 1'b0;
         use_mask = (mode == MODE_ERODE || mode == MODE_DILATE) ? se_mask : FULL_MASK;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               r   = out_row + dy;
               c   = out_col + dx;
               k   = (dy + 1) * 3 + (dx + 1);
               // neighbors off the image never count as object
               hit = 1'b0;
               if (r >= 0 && r < h && c >= 0 && c < w)
                  hit = (history[(r * w + c) % HIST_DEPTH] == obj_val);
               if (use_mask[k]) begin
                  if (hit) any_hit = 1'b1;
                  else all_fit = 1'b0;
               end
            end
         end
         centre = history[(out_row * w + out_col) % HIST_DEPTH];
         if (mode == MODE_DILATE) res = any_hit ? obj_val : bg_val;
         else res = all_fit ? obj_val : bg_val;
         // boundary: eroded minus centre, floored at zero
         if (mode >= MODE_BOUNDARY) res = (res > centre) ? res - centre : '0;
         return res;
      endfunction

      function void note_transfer(logic func, logic [PIX_W-1:0] pix);
         int           w, h, pos;
         bit           complete, ready;
         morph_pixel_t item;
         w        = active_width();
         h        = active_height();
         complete = (in_row >= h);
         if (out_row >= h) begin
            restart_frame();
            complete = 1'b0;
         end
         if (func == FUNC_PUSH && !complete) begin
            pos = in_row * w + in_col;
            history[pos % HIST_DEPTH] = pix;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
            ready = (out_row * w + out_col + w + 1) <= pos;
         end else begin
            // a drain flushes one result once the frame is in; so does a push then
            ready = complete;
         end
         if (!ready) return;
         item.pixel = filter_pixel(w, h);
         item.last  = (out_row == h - 1 && out_col >= w - 1);
         pending_q.push_back(item);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (out_row >= h) restart_frame();
      endfunction

      function void check_result(logic [PIX_W-1:0] pix, logic last);
         morph_pixel_t exp_item;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual pixel %h last %b",
                     $realtime, pix, last);
            errors++;
            return;
         end
         exp_item = pending_q.pop_front();
         if (pix !== exp_item.pixel) begin
            $display("%0t: pixel_out mismatch: expected %h, actual %h",
                     $realtime, exp_item.pixel, pix);
            errors++;
         end
         if (last !== exp_item.last) begin
            $display("%0t: frame_last mismatch: expected %b, actual %b",
                     $realtime, exp_item.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [PIX_W-1:0]  req_tdata = '0;   // [7:0] pixel_in
   logic              req_tuser = FUNC_PUSH;   // [0] func
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [PIX_W-1:0]  rsp_tdata;   // [7:0] pixel_out
   logic              rsp_tlast;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   morph_scoreboard morph_sb;
   int              burst_left = 0;
   int              random_pushes = 0;
   int              cycle_count = 0;
   logic [31:0]     rx_cycle = '0;

   always #5 clock = ~clock;

   binary_morphology_3x3 u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Result side: stall pattern changes with rx_cycle[10:9], check each transfer
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) morph_sb.check_result(rsp_tdata, rsp_tlast);
         rx_cycle <= rx_cycle + 1;
         case (rx_cycle[10:9])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2'd2: rsp_tready <= (rx_cycle[2:0] < 3'd3);
            default: rsp_tready <= ($urandom_range(0, 6) != 0);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $realtime);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // sender pacing: bursts of random length, occasionally long, then a gap
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 30);
      end
   endtask

   task automatic send_item(logic func, logic [PIX_W-1:0] pix);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      morph_sb.note_transfer(func, pix);
      pace_sender();
   endtask

   // wait until every predicted pixel has come out, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (morph_sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup and access cycle; psel stays up for back-to-back writes
   task automatic csr_write(logic [REG_IW-1:0] idx, logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      morph_sb.write_reg(idx, value);
   endtask

   task automatic configure(logic [MODE_W-1:0] m, logic [MASK_W-1:0] msk,
                            logic [PIX_W-1:0] ov, logic [PIX_W-1:0] bv,
                            logic [WREG_W-1:0] wr, logic [HREG_W-1:0] hr);
      wait_idle();
      csr_write(REG_MODE, m);
      csr_write(REG_MASK, msk);
      csr_write(REG_OBJECT, ov);
      csr_write(REG_BACKGR, bv);
      csr_write(REG_WIDTH, wr);
      csr_write(REG_HEIGHT, hr);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // object pixels for obj_pct percent, background for ten more, the rest anything
   function automatic logic [PIX_W-1:0] pick_pixel(int obj_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < obj_pct) return morph_sb.obj_val;
      if (roll < obj_pct + 10) return morph_sb.bg_val;
      return $urandom_range(0, 255);
   endfunction

   // one whole frame: pixels with stray drains, then the flush transfers
   task automatic run_frame(int obj_pct, int noise_pct);
      int w, h, n_pix, flush;
      w     = morph_sb.active_width();
      h     = morph_sb.active_height();
      n_pix = w * h;
      flush = (n_pix < w + 1) ? n_pix : w + 1;
      for (int i = 0; i < n_pix; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(FUNC_DRAIN, $urandom_range(0, 255));
         send_item(FUNC_PUSH, pick_pixel(obj_pct));
         random_pushes++;
      end
      // pushes past the frame end act as drains
      for (int i = 0; i < flush; i++) begin
         if ($urandom_range(0, 1) == 1) send_item(FUNC_DRAIN, $urandom_range(0, 255));
         else send_item(FUNC_PUSH, $urandom_range(0, 255));
      end
      // drain with nothing left to flush
      if ($urandom_range(0, 3) == 0) send_item(FUNC_DRAIN, $urandom_range(0, 255));
   endtask

   function automatic logic [PIX_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [MASK_W-1:0] msk;
      logic [WREG_W-1:0] wr;
      logic [HREG_W-1:0] hr;
      morph_sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // small erode frame: object block with two holes, early drain,
      // mixed drain / push flush, and a drain after the frame is out
      configure(MODE_ERODE, FULL_MASK, 8'h00, 8'hFF, 11'd3, 13'd3);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_item(FUNC_DRAIN, 8'h00);
         send_item(FUNC_PUSH, (i == 5 || i == 7) ? 8'hFF : 8'h00);
      end
      send_item(FUNC_DRAIN, 8'hFF);
      send_item(FUNC_PUSH, 8'hA5);
      send_item(FUNC_DRAIN, 8'h00);
      send_item(FUNC_PUSH, 8'h5A);
      send_item(FUNC_DRAIN, 8'hFF);

      // empty mask in erode and dilate, spare mode, zero sizes, boundary
      configure(MODE_ERODE, '0, 8'hFF, 8'h00, 11'd2, 13'd2);
      run_frame(60, 0);
      configure(MODE_DILATE, '0, 8'hFF, 8'h00, 11'd3, 13'd2);
      run_frame(60, 0);
      configure(MODE_SPARE, FULL_MASK, 8'h80, 8'hFF, 11'd0, 13'd0);
      run_frame(60, 0);
      configure(MODE_BOUNDARY, 9'h0AA, 8'hFF, 8'h7F, 11'd4, 13'd3);
      run_frame(70, 0);

      // largest sizes: over-range width on one row, over-range height on one column
      configure(MODE_DILATE, 9'h1FF, 8'h00, 8'hFF, 11'h7FF, 13'd1);
      run_frame(30, 1);
      configure(MODE_ERODE, 9'h1FF, 8'hFF, 8'h00, 11'd1024, 13'd2);
      run_frame(80, 1);
      configure(MODE_BOUNDARY, '0, 8'hC3, 8'h3C, 11'd1, 13'h1FFF);
      run_frame(70, 1);
      random_pushes = 0;

      // random settings, small frames
      while (random_pushes < RANDOM_PUSHES) begin
         case ($urandom_range(0, 5))
            0: msk = '0;
            1: msk = FULL_MASK;
            default: msk = $urandom_range(0, 511);
         endcase
         wr = ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 10));
         hr = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
         configure($urandom_range(0, 3), msk, pick_level(), pick_level(), wr, hr);
         repeat ($urandom_range(1, 3)) run_frame($urandom_range(40, 90), 5);
      end

      wait_idle();
      repeat (12) @(posedge clock);
      if (morph_sb.errors == 0 && morph_sb.pending_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
